### hdl/ptdt_pkg.sv
// Package: slot record layout, opcode and result kind codes, FSM states, helpers.
package ptdt_pkg;

    localparam int IN_DATA_W  = 288;
    localparam int OUT_DATA_W = 168;

    localparam logic [31:0] ALL_ONES  = 32'hFFFF_FFFF;
    localparam logic [9:0]  US_PER_MS = 10'd1000;

    // opcodes
    localparam logic [2:0] OP_ADD    = 3'd0;
    localparam logic [2:0] OP_REMOVE = 3'd1;
    localparam logic [2:0] OP_SET    = 3'd2;
    localparam logic [2:0] OP_SCAN   = 3'd3;
    localparam logic [2:0] OP_DONE   = 3'd4;

    // result kinds
    localparam logic [2:0] KIND_DISPATCH  = 3'd0;
    localparam logic [2:0] KIND_WAKE      = 3'd1;
    localparam logic [2:0] KIND_ADDED     = 3'd2;
    localparam logic [2:0] KIND_ACK       = 3'd3;
    localparam logic [2:0] KIND_FULL      = 3'd4;
    localparam logic [2:0] KIND_NOT_FOUND = 3'd5;
    localparam logic [2:0] KIND_SCAN_END  = 3'd6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_DIV,
        ST_CWB,
        ST_TAIL
    } state_t;

    typedef struct packed {
        logic [31:0] id;
        logic        en;
        logic        ev;
        logic        imm;
        logic        run;
        logic [31:0] next_time;
        logic [31:0] period;
        logic [31:0] tag;
        logic [31:0] run_count;
        logic [63:0] total;
        logic [31:0] avg;
        logic [31:0] max;
    } slot_rec_t;

    // time plus delay, saturating at all ones
    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? ALL_ONES : s[31:0];
    endfunction

endpackage

### hdl/periodic_task_dispatch_table.sv
// Periodic task dispatch table: slot memory, sequencer and completion divider.
//
// Input words arrive on the s_axis channel: tuser carries the opcode, tdata the
// operands. Results leave on m_axis: tuser carries the result kind, tdata the
// result fields, tlast marks the final result of each input word.
// Slot records live in one record memory with a registered read; the per-slot
// valid bits are kept in a separate register. Every command walks the slots in
// order, each slot taking a read state and then an evaluate state that may write
// back; a scan always walks all slots unless a zero budget stops it early.
// A completion adds a 64-step restoring division of total cost by run count.
// One word is worked on at a time; the next word is taken once the last result
// has moved into the output register, even while that result waits.
// Reset clears the per-slot valid bits (an unwritten slot reads as free and
// idle) and sets the next task ID to one; no clearing pass is needed.
// If the receiver stalls, the sequencer holds its place until the output
// register frees; no result is dropped or repeated.
module periodic_task_dispatch_table #(
    parameter int SLOTS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // now_ms, due_ms, period_ms, task_id, enable, next_offset_ms, budget_ms,
    // elapsed_us, slept_us, job_tag (lowest first)
    input  logic [ptdt_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // opcode
    input  logic [2:0]                       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // task_id_res, job_tag_res, slot, sleep_ms, avg_cost_us, max_cost_us, pad
    output logic [ptdt_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // kind
    output logic [2:0]                       m_axis_tuser,
    output logic                             m_axis_tlast
);
    import ptdt_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

    state_t state_reg, state_next;

    // captured command
    logic [2:0]  op_reg;
    logic [31:0] now_reg, due_reg, per_reg, id_reg, off_reg, budget_reg, el_reg, tag_reg;
    logic        en_reg;
    logic [30:0] slept_reg;
    logic [41:0] lim_reg;

    logic [IW-1:0] idx_reg;
    logic [31:0]   next_id_reg;
    logic [32:0]   earliest_reg;
    logic [2:0]    tail_kind_reg;

    // slot memory
    slot_rec_t       rec_mem [SLOTS];
    slot_rec_t       rd_q;
    logic            rd_valid_q;
    logic [SLOTS-1:0] valid_reg;

    // completion work
    slot_rec_t   upd_reg;
    logic [32:0] rem_reg;
    logic [63:0] quo_reg;
    logic [5:0]  cnt_reg;

    // output register
    logic         m_valid_reg;
    logic [2:0]   o_kind_reg;
    logic [31:0]  o_id_reg, o_tag_reg, o_sleep_reg, o_avg_reg, o_max_reg;
    logic [3:0]   o_slot_reg;
    logic         o_last_reg;

    logic accept, out_free;
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);

    // ---------------- decode of the current slot ----------------
    slot_rec_t   cur, add_rec, cmd_rec, scan_rec, done_rec;
    logic        id_hit, free_hit, at_end, due_now, disp;
    logic [32:0] cand, ear_new;
    logic [31:0] mag, ct, wake_sleep;
    logic [64:0] tot_sum;
    logic [31:0] avg_fin;

    always_comb
    begin
        cur      = rd_valid_q ? rd_q : '0;
        id_hit   = (cur.id == id_reg) && (id_reg != 32'd0);
        free_hit = (cur.id == 32'd0);
        at_end   = (idx_reg == LAST_IDX);
        due_now  = cur.imm || (cur.next_time <= now_reg);
        disp     = (cur.id != 32'd0) && cur.en && !cur.run && due_now
                   && ({10'd0, cur.avg} <= lim_reg);

        // new record for add
        add_rec           = '0;
        add_rec.id        = next_id_reg;
        add_rec.ev        = due_reg[31];
        add_rec.imm       = due_reg[31];
        add_rec.en        = !due_reg[31];
        add_rec.next_time = due_reg[31] ? 32'd0 : sat_add(now_reg, due_reg);
        add_rec.period    = per_reg;
        add_rec.tag       = tag_reg;

        // remove / set
        cmd_rec = cur;
        if (op_reg == OP_REMOVE)
        begin
            cmd_rec.id = 32'd0;
        end
        else
        begin
            cmd_rec.en = en_reg;
            if (!off_reg[31])
            begin
                cmd_rec.next_time = sat_add(now_reg, off_reg);
                cmd_rec.imm       = 1'b0;
            end
        end

        // scan dispatch
        scan_rec = cur;
        if (disp)
        begin
            scan_rec.run = 1'b1;
            if (cur.ev)
            begin
                scan_rec.en = 1'b0;
            end
            else
            begin
                scan_rec.next_time = cur.period[31] ? now_reg : sat_add(now_reg, cur.period);
                scan_rec.imm       = 1'b0;
            end
        end
        cand = {1'b1, ALL_ONES};
        if (scan_rec.id != 32'd0 && scan_rec.en)
        begin
            cand = scan_rec.imm ? 33'd0 : {1'b0, scan_rec.next_time};
        end
        ear_new = (cand < earliest_reg) ? cand : earliest_reg;

        // completion statistics
        mag     = el_reg[31] ? (32'd0 - el_reg) : el_reg;
        ct      = (mag > {1'b0, slept_reg}) ? (mag - {1'b0, slept_reg}) : 32'd0;
        tot_sum = {1'b0, cur.total} + {33'd0, ct};
        done_rec = cur;
        done_rec.run = 1'b0;
        if (cur.run_count != ALL_ONES)
        begin
            done_rec.run_count = cur.run_count + 32'd1;
        end
        if (ct > cur.max)
        begin
            done_rec.max = ct;
        end
        done_rec.total = tot_sum[64] ? {ALL_ONES, ALL_ONES} : tot_sum[63:0];
        if (!cur.ev && cur.period[31])
        begin
            done_rec.id = 32'd0;
        end

        avg_fin = (quo_reg[63:32] != 32'd0) ? ALL_ONES : quo_reg[31:0];

        wake_sleep = 32'd0;
        if (budget_reg == ALL_ONES && !earliest_reg[32] && earliest_reg[31:0] > now_reg)
        begin
            wake_sleep = earliest_reg[31:0] - now_reg;
        end
    end

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_axis_tuser > OP_DONE)
                        state_next = ST_IDLE;
                    else if ((s_axis_tuser == OP_REMOVE || s_axis_tuser == OP_SET
                              || s_axis_tuser == OP_DONE) && s_axis_tdata[127:96] == 32'd0)
                        state_next = ST_TAIL;
                    else
                        state_next = ST_READ;
                end
            end
            ST_READ: state_next = ST_EVAL;
            ST_EVAL:
            begin
                if (out_free)
                begin
                    priority case (op_reg)
                        OP_ADD:
                            state_next = free_hit ? ST_IDLE : (at_end ? ST_TAIL : ST_READ);
                        OP_REMOVE, OP_SET:
                            state_next = id_hit ? ST_IDLE : (at_end ? ST_TAIL : ST_READ);
                        OP_DONE:
                            state_next = (id_hit && cur.run) ? ST_DIV
                                       : ((id_hit || at_end) ? ST_TAIL : ST_READ);
                        OP_SCAN:
                            state_next = (disp && budget_reg == 32'd0) ? ST_TAIL
                                       : (at_end ? ST_TAIL : ST_READ);
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_DIV:  state_next = (cnt_reg == 6'd63) ? ST_CWB : ST_DIV;
            ST_CWB:  state_next = out_free ? ST_IDLE : ST_CWB;
            ST_TAIL: state_next = out_free ? ST_IDLE : ST_TAIL;
            default: state_next = ST_IDLE;
        endcase
    end

    // ---------------- actions ----------------
    logic        mem_we, out_load, tail_set, idx_inc, ear_upd, div_start, nid_inc;
    slot_rec_t   mem_wdata;
    logic [2:0]  o_kind, tail_kind_next;
    logic [31:0] o_id, o_tag, o_sleep, o_avg, o_max;
    logic        o_last;

    always_comb
    begin
        mem_we = 1'b0; mem_wdata = cur; out_load = 1'b0; tail_set = 1'b0;
        tail_kind_next = KIND_NOT_FOUND; idx_inc = 1'b0; ear_upd = 1'b0;
        div_start = 1'b0; nid_inc = 1'b0;
        o_kind = KIND_ACK; o_id = 32'd0; o_tag = 32'd0; o_sleep = 32'd0;
        o_avg = 32'd0; o_max = 32'd0; o_last = 1'b1;
        unique case (state_reg)
            ST_EVAL:
            begin
                if (out_free)
                begin
                    priority case (op_reg)
                        OP_ADD:
                        begin
                            if (free_hit)
                            begin
                                mem_we = 1'b1; mem_wdata = add_rec; nid_inc = 1'b1;
                                out_load = 1'b1; o_kind = KIND_ADDED; o_id = next_id_reg;
                            end
                            else if (at_end)
                            begin
                                tail_set = 1'b1; tail_kind_next = KIND_FULL;
                            end
                            else
                                idx_inc = 1'b1;
                        end
                        OP_REMOVE, OP_SET:
                        begin
                            if (id_hit)
                            begin
                                mem_we = 1'b1; mem_wdata = cmd_rec;
                                out_load = 1'b1; o_kind = KIND_ACK; o_id = id_reg;
                            end
                            else if (at_end)
                                tail_set = 1'b1;
                            else
                                idx_inc = 1'b1;
                        end
                        OP_DONE:
                        begin
                            if (id_hit && cur.run)
                                div_start = 1'b1;
                            else if (id_hit || at_end)
                                tail_set = 1'b1;
                            else
                                idx_inc = 1'b1;
                        end
                        OP_SCAN:
                        begin
                            ear_upd = 1'b1;
                            if (disp)
                            begin
                                mem_we = 1'b1; mem_wdata = scan_rec; out_load = 1'b1;
                                o_kind = KIND_DISPATCH; o_id = cur.id; o_tag = cur.tag;
                                o_last = 1'b0;
                            end
                            if (disp && budget_reg == 32'd0)
                            begin
                                tail_set = 1'b1; tail_kind_next = KIND_SCAN_END;
                            end
                            else if (at_end)
                            begin
                                tail_set = 1'b1; tail_kind_next = KIND_WAKE;
                            end
                            else
                                idx_inc = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            ST_CWB:
            begin
                if (out_free)
                begin
                    mem_we = 1'b1; mem_wdata = upd_reg; mem_wdata.avg = avg_fin;
                    out_load = 1'b1; o_kind = KIND_ACK; o_id = id_reg;
                    o_avg = avg_fin; o_max = upd_reg.max;
                end
            end
            ST_TAIL:
            begin
                if (out_free)
                begin
                    out_load = 1'b1; o_kind = tail_kind_reg;
                    o_sleep = (tail_kind_reg == KIND_WAKE) ? wake_sleep : 32'd0;
                end
            end
            ST_IDLE, ST_READ, ST_DIV: ;
            default: ;
        endcase
    end

    // ---------------- slot memory ----------------
    always_ff @(posedge clk)
    begin
        if (mem_we)
            rec_mem[idx_reg] <= mem_wdata;
        if (state_reg == ST_READ)
            rd_q <= rec_mem[idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_valid_q <= 1'b0;
        end
        else
        begin
            if (mem_we)
                valid_reg[idx_reg] <= 1'b1;
            if (state_reg == ST_READ)
                rd_valid_q <= valid_reg[idx_reg];
        end
    end

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            next_id_reg   <= 32'd1;
            tail_kind_reg <= KIND_NOT_FOUND;
            cnt_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                idx_reg       <= '0;
                tail_kind_reg <= KIND_NOT_FOUND;
            end
            else if (idx_inc)
                idx_reg <= idx_reg + 1'b1;
            if (tail_set)
                tail_kind_reg <= tail_kind_next;
            if (nid_inc)
                next_id_reg <= (next_id_reg == ALL_ONES) ? 32'd1 : next_id_reg + 32'd1;
            if (div_start)
                cnt_reg <= '0;
            else if (state_reg == ST_DIV)
                cnt_reg <= cnt_reg + 6'd1;
            if (out_load)
                m_valid_reg <= 1'b1;
            else if (m_axis_tready)
                m_valid_reg <= 1'b0;
        end
    end

    // ---------------- payload registers ----------------
    logic [32:0] rem_sh;
    assign rem_sh = {rem_reg[31:0], quo_reg[63]};

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= s_axis_tuser;
            now_reg    <= s_axis_tdata[31:0];
            due_reg    <= s_axis_tdata[63:32];
            per_reg    <= s_axis_tdata[95:64];
            id_reg     <= s_axis_tdata[127:96];
            en_reg     <= s_axis_tdata[128];
            off_reg    <= s_axis_tdata[160:129];
            budget_reg <= s_axis_tdata[192:161];
            el_reg     <= s_axis_tdata[224:193];
            slept_reg  <= s_axis_tdata[255:225];
            tag_reg    <= s_axis_tdata[287:256];
            // avg/1000 <= budget  <=>  avg <= budget*1000 + 999
            lim_reg    <= 42'(s_axis_tdata[192:161]) * 42'(US_PER_MS) + 42'(US_PER_MS - 10'd1);
            earliest_reg <= {1'b1, ALL_ONES};
        end
        else if (ear_upd)
            earliest_reg <= ear_new;

        // restoring divide: total / run count, one quotient bit a cycle
        if (div_start)
        begin
            upd_reg <= done_rec;
            rem_reg <= '0;
            quo_reg <= done_rec.total;
        end
        else if (state_reg == ST_DIV)
        begin
            if (rem_sh >= {1'b0, upd_reg.run_count})
            begin
                rem_reg <= rem_sh - {1'b0, upd_reg.run_count};
                quo_reg <= {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[62:0], 1'b0};
            end
        end

        if (out_load)
        begin
            o_kind_reg  <= o_kind;
            o_id_reg    <= o_id;
            o_tag_reg   <= o_tag;
            o_slot_reg  <= (o_kind == KIND_DISPATCH || o_kind == KIND_ADDED
                            || o_kind == KIND_ACK) ? 4'(idx_reg) : 4'd0;
            o_sleep_reg <= o_sleep;
            o_avg_reg   <= o_avg;
            o_max_reg   <= o_max;
            o_last_reg  <= o_last;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = o_kind_reg;
    assign m_axis_tlast  = o_last_reg;
    assign m_axis_tdata  = {4'd0, o_max_reg, o_avg_reg, o_sleep_reg, o_slot_reg,
                            o_tag_reg, o_id_reg};

    // ---------------- assertions ----------------
    a_we_states: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ST_EVAL || state_reg == ST_CWB))
        else $error("slot write outside evaluate or write-back");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!m_valid_reg || m_axis_tready))
        else $error("output register overwritten while held");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_axis_tuser <= OP_DONE) |=> (state_reg != ST_IDLE))
        else $error("known opcode accepted without work");

    a_div_no_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (!out_load && !mem_we))
        else $error("result or write during divide");

endmodule

### verif/periodic_task_dispatch_table_test.sv
// Testbench for the periodic task dispatch table: directed table plus random words.
`timescale 1ns / 1ps

module periodic_task_dispatch_table_test;
    import ptdt_pkg::*;

    localparam int NSLOT      = 16;
    localparam int STALL_MAX  = 5000;
    localparam int RAND_ITEMS = 84;

    // one input word, fields as the block sees them
    typedef struct {
        logic [2:0]  op;
        logic [31:0] now;
        logic [31:0] due;
        logic [31:0] per;
        logic [31:0] id;
        logic        en;
        logic [31:0] off;
        logic [31:0] budget;
        logic [31:0] el;
        logic [30:0] slept;
        logic [31:0] tag;
        bit          chk;
        logic [2:0]  exp_kind;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] id;
        logic [31:0] tag;
        logic [3:0]  slot;
        logic [31:0] sleep;
        logic [31:0] avg;
        logic [31:0] max;
        logic        last;
    } res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata = '0;
    logic [2:0] s_axis_tuser = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [2:0] m_axis_tuser;
    logic m_axis_tlast;

    periodic_task_dispatch_table #(.SLOTS(NSLOT)) u_top (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    always #2 clk = ~clk;

    // scheduler shadow state
    logic [31:0] t_id [NSLOT];
    logic        t_en [NSLOT];
    logic        t_ev [NSLOT];
    logic        t_imm [NSLOT];
    logic        t_run [NSLOT];
    logic [31:0] t_next [NSLOT];
    logic [31:0] t_per [NSLOT];
    logic [31:0] t_tag [NSLOT];
    logic [31:0] t_cnt [NSLOT];
    logic [63:0] t_total [NSLOT];
    logic [31:0] t_avg [NSLOT];
    logic [31:0] t_max [NSLOT];
    logic [31:0] id_seq;

    res_t pending_results[$];
    int   mismatches = 0;
    int   idle_cycles = 0;
    bit   rx_fast = 1'b0;

    function automatic logic [31:0] clip_add(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? ALL_ONES : s[31:0];
    endfunction

    function automatic int slot_of(logic [31:0] id);
        if (id == 0) return -1;
        for (int i = 0; i < NSLOT; i++)
            if (t_id[i] == id) return i;
        return -1;
    endfunction

    function automatic void expect_word(logic [2:0] k, logic [31:0] id, logic [31:0] tg,
                                        int s, logic [31:0] sl, logic [31:0] av,
                                        logic [31:0] mx, logic lst);
        res_t r;
        r.kind = k; r.id = id; r.tag = tg; r.slot = s[3:0];
        r.sleep = sl; r.avg = av; r.max = mx; r.last = lst;
        pending_results.push_back(r);
    endfunction

    // work out the results of one word and update the shadow state
    function automatic void schedule_word(cmd_t c);
        int s;
        logic [63:0] earliest;
        logic [31:0] mag, cost, sl;
        logic [63:0] q;
        case (c.op)
            OP_ADD:
            begin
                s = -1;
                for (int i = 0; i < NSLOT; i++)
                    if (s < 0 && t_id[i] == 0) s = i;
                if (s < 0)
                    expect_word(KIND_FULL, 0, 0, 0, 0, 0, 0, 1'b1);
                else
                begin
                    t_id[s] = id_seq;
                    id_seq = id_seq + 1;
                    if (id_seq == 0) id_seq = 1;
                    t_tag[s] = c.tag; t_per[s] = c.per;
                    t_ev[s] = c.due[31]; t_imm[s] = c.due[31]; t_en[s] = !c.due[31];
                    t_next[s] = c.due[31] ? 32'd0 : clip_add(c.now, c.due);
                    t_run[s] = 0; t_cnt[s] = 0; t_total[s] = 0; t_avg[s] = 0; t_max[s] = 0;
                    expect_word(KIND_ADDED, t_id[s], 0, s, 0, 0, 0, 1'b1);
                end
            end
            OP_REMOVE, OP_SET:
            begin
                s = slot_of(c.id);
                if (s < 0)
                    expect_word(KIND_NOT_FOUND, 0, 0, 0, 0, 0, 0, 1'b1);
                else
                begin
                    if (c.op == OP_REMOVE)
                        t_id[s] = 0;
                    else
                    begin
                        t_en[s] = c.en;
                        if (!c.off[31])
                        begin
                            t_next[s] = clip_add(c.now, c.off);
                            t_imm[s] = 0;
                        end
                    end
                    expect_word(KIND_ACK, c.id, 0, s, 0, 0, 0, 1'b1);
                end
            end
            OP_SCAN:
            begin
                earliest = '1;
                sl = 0;
                for (int i = 0; i < NSLOT; i++)
                begin
                    if (t_id[i] == 0 || !t_en[i]) continue;
                    if (!t_run[i] && (t_imm[i] || t_next[i] <= c.now)
                        && (t_avg[i] / 1000) <= c.budget)
                    begin
                        t_run[i] = 1;
                        if (t_ev[i])
                            t_en[i] = 0;
                        else
                        begin
                            t_next[i] = t_per[i][31] ? c.now : clip_add(c.now, t_per[i]);
                            t_imm[i] = 0;
                        end
                        expect_word(KIND_DISPATCH, t_id[i], t_tag[i], i, 0, 0, 0, 1'b0);
                        if (c.budget == 0)
                        begin
                            expect_word(KIND_SCAN_END, 0, 0, 0, 0, 0, 0, 1'b1);
                            return;
                        end
                    end
                    if (t_en[i])
                    begin
                        if (t_imm[i]) earliest = 0;
                        else if ({32'd0, t_next[i]} < earliest) earliest = {32'd0, t_next[i]};
                    end
                end
                if (c.budget == ALL_ONES && earliest != '1 && earliest > {32'd0, c.now})
                    sl = earliest[31:0] - c.now;
                expect_word(KIND_WAKE, 0, 0, 0, sl, 0, 0, 1'b1);
            end
            OP_DONE:
            begin
                s = slot_of(c.id);
                if (s < 0 || !t_run[s])
                    expect_word(KIND_NOT_FOUND, 0, 0, 0, 0, 0, 0, 1'b1);
                else
                begin
                    mag = c.el[31] ? (32'd0 - c.el) : c.el;
                    cost = (mag > {1'b0, c.slept}) ? mag - {1'b0, c.slept} : 32'd0;
                    if (t_cnt[s] != ALL_ONES) t_cnt[s] = t_cnt[s] + 1;
                    if (cost > t_max[s]) t_max[s] = cost;
                    if (t_total[s] > ~64'd0 - cost) t_total[s] = ~64'd0;
                    else t_total[s] = t_total[s] + cost;
                    q = t_total[s] / t_cnt[s];
                    t_avg[s] = (q > {32'd0, ALL_ONES}) ? ALL_ONES : q[31:0];
                    t_run[s] = 0;
                    expect_word(KIND_ACK, c.id, 0, s, 0, t_avg[s], t_max[s], 1'b1);
                    if (!t_ev[s] && t_per[s][31]) t_id[s] = 0;
                end
            end
            default: ;  // unknown opcode: no results
        endcase
    endfunction

    function automatic cmd_t mk(logic [2:0] op, logic [31:0] now, logic [31:0] due,
                                logic [31:0] per, logic [31:0] id, logic en,
                                logic [31:0] off, logic [31:0] budget, logic [31:0] el,
                                logic [30:0] slept, logic [31:0] tag, bit chk,
                                logic [2:0] ek);
        cmd_t c;
        c.op = op; c.now = now; c.due = due; c.per = per; c.id = id; c.en = en;
        c.off = off; c.budget = budget; c.el = el; c.slept = slept; c.tag = tag;
        c.chk = chk; c.exp_kind = ek;
        return c;
    endfunction

    // present one word, wait for it to be taken, then the random gap
    task automatic send_word(cmd_t c, int gap);
        int n0;
        logic [2:0] pk;
        n0 = pending_results.size();
        schedule_word(c);
        pk = (pending_results.size() == n0) ? 3'd7 : pending_results[n0].kind;
        if (c.chk && (pending_results.size() == n0 || pk != c.exp_kind))
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("directed row op %0d: exp kind %0d, predicted kind %0d",
                         c.op, c.exp_kind, pk);
        end
        s_axis_tuser <= c.op;
        s_axis_tdata <= {c.tag, c.slept, c.el, c.budget, c.off, c.en, c.id, c.per,
                         c.due, c.now};
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        res_t got, want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            got.kind = m_axis_tuser;
            got.id = m_axis_tdata[31:0];
            got.tag = m_axis_tdata[63:32];
            got.slot = m_axis_tdata[67:64];
            got.sleep = m_axis_tdata[99:68];
            got.avg = m_axis_tdata[131:100];
            got.max = m_axis_tdata[163:132];
            got.last = m_axis_tlast;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word %p", got);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10) $display("mismatch exp %p got %p", want, got);
                end
            end
        end
    end

    // receiver stalls: random ready gaps after each word, none while rx_fast
    always @(posedge clk)
    begin
        int wait_left;
        if (!rst_n)
            wait_left = 0;
        else if (m_axis_tvalid && m_axis_tready)
        begin
            wait_left = rx_fast ? 0 : $urandom_range(0, 15);
            m_axis_tready <= (wait_left == 0);
        end
        else if (wait_left > 0)
        begin
            wait_left--;
            m_axis_tready <= (wait_left == 0);
        end
        else
            m_axis_tready <= 1'b1;
    end

    // watchdog on cycles with no word moved
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_MAX)
        begin
            $display("FAIL periodic_task_dispatch_table");
            $finish;
        end
    end

    initial
    begin
        cmd_t dir[$];
        cmd_t c;
        logic [31:0] clock_ms;
        int r, s, gap, tries;
        bit tx_fast;

        for (int i = 0; i < NSLOT; i++)
        begin
            t_id[i] = 0; t_en[i] = 0; t_ev[i] = 0; t_imm[i] = 0; t_run[i] = 0;
            t_next[i] = 0; t_per[i] = 0; t_tag[i] = 0; t_cnt[i] = 0; t_total[i] = 0;
            t_avg[i] = 0; t_max[i] = 0;
        end
        id_seq = 1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows
        dir.push_back(mk(OP_SCAN, 0, 0, 0, 0, 0, 0, ALL_ONES, 0, 0, 0, 1, KIND_WAKE));
        dir.push_back(mk(OP_REMOVE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, KIND_NOT_FOUND));
        dir.push_back(mk(OP_SET, 0, 0, 0, 7, 1, 0, 0, 0, 0, 0, 1, KIND_NOT_FOUND));
        dir.push_back(mk(OP_DONE, 0, 0, 0, 1, 0, 0, 0, 5, 0, 0, 1, KIND_NOT_FOUND));
        dir.push_back(mk(OP_ADD, 10, 100, 50, 0, 0, 0, 0, 0, 0, 32'hA5A5_0001, 1, KIND_ADDED));
        dir.push_back(mk(OP_ADD, 10, 32'h8000_0000, 20, 0, 0, 0, 0, 0, 0, ALL_ONES, 1,
                         KIND_ADDED));
        dir.push_back(mk(OP_ADD, 10, 0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 3, 1, KIND_ADDED));
        dir.push_back(mk(OP_ADD, ALL_ONES, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0,
                         4, 1, KIND_ADDED));
        dir.push_back(mk(OP_SCAN, 20, 0, 0, 0, 0, 0, ALL_ONES, 0, 0, 0, 0, 0));
        dir.push_back(mk(OP_SET, 20, 0, 0, 2, 1, 32'hFFFF_FFFF, 0, 0, 0, 0, 1, KIND_ACK));
        dir.push_back(mk(OP_SCAN, 25, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        dir.push_back(mk(OP_SCAN, 200, 0, 0, 0, 0, 0, ALL_ONES, 0, 0, 0, 0, 0));
        dir.push_back(mk(OP_DONE, 200, 0, 0, 1, 0, 0, 0, 32'h8000_0000, 0, 0, 1, KIND_ACK));
        dir.push_back(mk(OP_DONE, 200, 0, 0, 2, 0, 0, 0, 5, 31'h7FFF_FFFF, 0, 1, KIND_ACK));
        dir.push_back(mk(OP_DONE, 200, 0, 0, 3, 0, 0, 0, 32'h7FFF_FFFF, 0, 0, 1, KIND_ACK));
        dir.push_back(mk(OP_DONE, 200, 0, 0, 2, 0, 0, 0, 5, 0, 0, 1, KIND_NOT_FOUND));
        dir.push_back(mk(OP_SET, 300, 0, 0, 1, 1, 32'h7FFF_FFFF, 0, 0, 0, 0, 1, KIND_ACK));
        dir.push_back(mk(OP_SCAN, 300, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        dir.push_back(mk(3'd5, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, 1, ALL_ONES, ALL_ONES,
                         ALL_ONES, 31'h7FFF_FFFF, ALL_ONES, 0, 0));
        dir.push_back(mk(3'd7, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        dir.push_back(mk(OP_REMOVE, 300, 0, 0, 4, 0, 0, 0, 0, 0, 0, 1, KIND_ACK));
        foreach (dir[i])
            send_word(dir[i], $urandom_range(0, 15));

        // fill the table with more adds than slots; the last add must be refused
        for (int i = 0; i <= NSLOT; i++)
            send_word(mk(OP_ADD, 300, $urandom_range(0, 40), $urandom_range(0, 60), 0, 0, 0,
                         0, 0, 0, $urandom, i == NSLOT, KIND_FULL), $urandom_range(0, 3));

        // random traffic, mostly live task ids and a moving clock
        clock_ms = 300;
        tx_fast = 0;
        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            if (n % 30 == 0)
            begin
                tx_fast = 1'($urandom_range(0, 1));
                rx_fast = 1'($urandom_range(0, 1));
            end
            if (n == 60)
            begin
                s_axis_tvalid <= 1'b0;
                while (pending_results.size() != 0) @(posedge clk);
            end
            clock_ms = clock_ms + $urandom_range(0, 40);
            c = mk(OP_SCAN, clock_ms, $urandom_range(0, 80), $urandom_range(0, 80), 0,
                   1'($urandom_range(0, 1)), $urandom_range(0, 80), ALL_ONES,
                   $urandom_range(0, 90000), 31'($urandom_range(0, 20000)), $urandom, 0, 0);
            if ($urandom_range(0, 9) == 0) c.due = $urandom;
            if ($urandom_range(0, 9) == 0) c.per = $urandom;
            if ($urandom_range(0, 9) == 0) c.off = $urandom;
            s = $urandom_range(0, NSLOT - 1);
            c.id = ($urandom_range(0, 9) == 0) ? $urandom : t_id[s];
            r = $urandom_range(0, 99);
            if (r < 18) c.op = OP_ADD;
            else if (r < 28) c.op = OP_REMOVE;
            else if (r < 45) c.op = OP_SET;
            else if (r < 70)
            begin
                c.op = OP_SCAN;
                case ($urandom_range(0, 3))
                    0: c.budget = 0;
                    1: c.budget = $urandom_range(0, 100);
                    2: c.budget = $urandom;
                    default: c.budget = ALL_ONES;
                endcase
            end
            else if (r < 95)
            begin
                c.op = OP_DONE;
                tries = 0;
                while (tries < NSLOT && !(t_run[s] && t_id[s] != 0))
                begin
                    s = (s + 1) % NSLOT;
                    tries++;
                end
                if (tries < NSLOT) c.id = t_id[s];
                if ($urandom_range(0, 7) == 0) c.el = $urandom;
                if ($urandom_range(0, 7) == 0) c.slept = 31'($urandom);
            end
            else
            begin
                c.op = 3'($urandom_range(5, 7));
                c.now = $urandom; c.id = $urandom; c.budget = $urandom; c.el = $urandom;
                c.slept = 31'($urandom); c.tag = $urandom; c.en = 1'($urandom);
            end
            if ($urandom_range(0, 19) == 0) c.now = $urandom;
            gap = tx_fast ? 0 : $urandom_range(0, 15);
            send_word(c, gap);
        end
        s_axis_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("PASS periodic_task_dispatch_table");
        else
            $display("FAIL periodic_task_dispatch_table");
        $finish;
    end

endmodule
